[rtl/core/dam_pkg.sv]
// dram address mapper package: scheme and register codes, field layout type,
// fixed layout bit positions and the field extraction helper
// no dependencies; imported by every module of the mapper
package dam_pkg;

    // default physical address width
    localparam int ADDR_WIDTH_DEF = 32;

    // widths of the request and result fields
    localparam int PHYS_ADDR_W = 32;
    localparam int CHAN_ID_W   = 4;
    localparam int RANK_ID_W   = 4;
    localparam int BANK_ID_W   = 4;
    localparam int ROW_ID_W    = 20;
    localparam int COL_ID_W    = 16;

    // configuration port
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 5;

    // offsets of the layout are sums of configured depths
    localparam int OFF_W = 7;

    // mapping scheme codes
    localparam logic [2:0] SCHEME_BURGER     = 3'd0;
    localparam logic [2:0] SCHEME_OPEN_PAGE  = 3'd1;
    localparam logic [2:0] SCHEME_SDRAM      = 3'd2;
    localparam logic [2:0] SCHEME_FIXED      = 3'd3;
    localparam logic [2:0] SCHEME_CLOSE_PAGE = 3'd4;

    // register indexes
    localparam logic [2:0] REG_MAP_SCHEME    = 3'd0;
    localparam logic [2:0] REG_CHAN_BITS     = 3'd1;
    localparam logic [2:0] REG_RANK_BITS     = 3'd2;
    localparam logic [2:0] REG_BANK_BITS     = 3'd3;
    localparam logic [2:0] REG_ROW_BITS      = 3'd4;
    localparam logic [2:0] REG_COL_BITS      = 3'd5;
    localparam logic [2:0] REG_COL_SIZE_BITS = 3'd6;
    localparam logic [2:0] REG_LINE_BITS     = 3'd7;

    // register reset values
    localparam logic [2:0] RST_MAP_SCHEME    = SCHEME_OPEN_PAGE;
    localparam logic [2:0] RST_CHAN_BITS     = 3'd0;
    localparam logic [2:0] RST_RANK_BITS     = 3'd2;
    localparam logic [2:0] RST_BANK_BITS     = 3'd2;
    localparam logic [4:0] RST_ROW_BITS      = 5'd13;
    localparam logic [4:0] RST_COL_BITS      = 5'd10;
    localparam logic [2:0] RST_COL_SIZE_BITS = 3'd3;
    localparam logic [3:0] RST_LINE_BITS     = 4'd6;

    // fixed layout bit positions
    localparam int FIX_COL_LSB  = 3;
    localparam int FIX_COL_BITS = 10;
    localparam int FIX_BANK_LSB = 13;
    localparam int FIX_BIT15    = 15;
    localparam int FIX_MID_LSB  = 16;
    localparam int FIX_MID_BITS = 11;
    localparam int FIX_BIT27    = 27;
    localparam int FIX_RANK_LSB = 28;
    localparam int FIX_TOP_LSB  = 30;

    // fixed layout row bit positions of address bits 27 and 15
    localparam int FIX_ROW_TOP_POS = 13;
    localparam int FIX_ROW_B15_POS = 12;

    // how the datapath decodes a request
    typedef enum logic [1:0] {
        MODE_PEEL,
        MODE_FIXED,
        MODE_BAD
    } mode_t;

    // absolute bit offset and width of every field for the active scheme;
    // cola is the whole column or its low part, colb the high part
    typedef struct packed {
        mode_t            mode;
        logic [OFF_W-1:0] chan_off;
        logic [2:0]       chan_w;
        logic [OFF_W-1:0] rank_off;
        logic [2:0]       rank_w;
        logic [OFF_W-1:0] bank_off;
        logic [2:0]       bank_w;
        logic [OFF_W-1:0] row_off;
        logic [4:0]       row_w;
        logic [OFF_W-1:0] cola_off;
        logic [4:0]       cola_w;
        logic [OFF_W-1:0] colb_off;
        logic [4:0]       colb_w;
        logic [OFF_W-1:0] end_off;
    } layout_t;

    // bits [off +: w] of the address, zero where the field lies above it
    function automatic logic [PHYS_ADDR_W-1:0] field_extract(
        input logic [PHYS_ADDR_W-1:0] addr,
        input logic [OFF_W-1:0]       off,
        input logic [4:0]             w
    );
        logic [PHYS_ADDR_W-1:0] shifted;
        logic [PHYS_ADDR_W-1:0] mask;
        shifted = (off >= OFF_W'(PHYS_ADDR_W)) ? '0 : (addr >> off[4:0]);
        mask    = ~({PHYS_ADDR_W{1'b1}} << w);
        return shifted & mask;
    endfunction

    // true when any address bit at or above pos is set
    function automatic logic bits_above(
        input logic [PHYS_ADDR_W-1:0] addr,
        input logic [OFF_W-1:0]       pos
    );
        logic [PHYS_ADDR_W-1:0] shifted;
        shifted = (pos >= OFF_W'(PHYS_ADDR_W)) ? '0 : (addr >> pos[4:0]);
        return |shifted;
    endfunction

endpackage

[rtl/core/dam_cfg.sv]
// dram address mapper configuration registers with apb-style access,
// and the registered field layout derived from them
// depends on dam_pkg
module dam_cfg (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [dam_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [dam_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [dam_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                              pready,
    output dam_pkg::layout_t                  layout
);
    import dam_pkg::*;

    logic [2:0] map_scheme_reg;
    logic [2:0] chan_bits_reg;
    logic [2:0] rank_bits_reg;
    logic [2:0] bank_bits_reg;
    logic [4:0] row_bits_reg;
    logic [4:0] col_bits_reg;
    logic [2:0] col_size_bits_reg;
    logic [3:0] line_bits_reg;

    logic [2:0] reg_idx;
    logic       wr_en;
    logic [3:0] lo_w;
    logic [4:0] hi_w;
    layout_t    layout_next;
    layout_t    layout_reg;

    assign pready  = 1'b1;
    assign reg_idx = paddr[CFG_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_scheme_reg    <= RST_MAP_SCHEME;
            chan_bits_reg     <= RST_CHAN_BITS;
            rank_bits_reg     <= RST_RANK_BITS;
            bank_bits_reg     <= RST_BANK_BITS;
            row_bits_reg      <= RST_ROW_BITS;
            col_bits_reg      <= RST_COL_BITS;
            col_size_bits_reg <= RST_COL_SIZE_BITS;
            line_bits_reg     <= RST_LINE_BITS;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_MAP_SCHEME:    map_scheme_reg    <= pwdata[2:0];
                REG_CHAN_BITS:     chan_bits_reg     <= pwdata[2:0];
                REG_RANK_BITS:     rank_bits_reg     <= pwdata[2:0];
                REG_BANK_BITS:     bank_bits_reg     <= pwdata[2:0];
                REG_ROW_BITS:      row_bits_reg      <= pwdata[4:0];
                REG_COL_BITS:      col_bits_reg      <= pwdata[4:0];
                REG_COL_SIZE_BITS: col_size_bits_reg <= pwdata[2:0];
                REG_LINE_BITS:     line_bits_reg     <= pwdata[3:0];
                default:           ;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        prdata = '0;
        unique case (reg_idx)
            REG_MAP_SCHEME:    prdata = CFG_DATA_W'(map_scheme_reg);
            REG_CHAN_BITS:     prdata = CFG_DATA_W'(chan_bits_reg);
            REG_RANK_BITS:     prdata = CFG_DATA_W'(rank_bits_reg);
            REG_BANK_BITS:     prdata = CFG_DATA_W'(bank_bits_reg);
            REG_ROW_BITS:      prdata = CFG_DATA_W'(row_bits_reg);
            REG_COL_BITS:      prdata = CFG_DATA_W'(col_bits_reg);
            REG_COL_SIZE_BITS: prdata = CFG_DATA_W'(col_size_bits_reg);
            REG_LINE_BITS:     prdata = CFG_DATA_W'(line_bits_reg);
            default:           prdata = '0;
        endcase
    end

    // split column depths, clamped at zero
    always_comb
    begin
        lo_w = (line_bits_reg > 4'(col_size_bits_reg))
             ? line_bits_reg - 4'(col_size_bits_reg) : 4'd0;
        hi_w = (col_bits_reg > 5'(lo_w)) ? col_bits_reg - 5'(lo_w) : 5'd0;
    end

    // field offsets in peel order for the active scheme
    always_comb
    begin
        layout_next      = '0;
        layout_next.mode = MODE_BAD;
        unique case (map_scheme_reg)
            SCHEME_BURGER:
            begin
                layout_next.mode     = MODE_PEEL;
                layout_next.chan_w   = chan_bits_reg;
                layout_next.cola_w   = col_bits_reg;
                layout_next.rank_w   = rank_bits_reg;
                layout_next.bank_w   = bank_bits_reg;
                layout_next.row_w    = row_bits_reg;
                layout_next.chan_off = OFF_W'(col_size_bits_reg);
                layout_next.cola_off = layout_next.chan_off + OFF_W'(chan_bits_reg);
                layout_next.rank_off = layout_next.cola_off + OFF_W'(col_bits_reg);
                layout_next.bank_off = layout_next.rank_off + OFF_W'(rank_bits_reg);
                layout_next.row_off  = layout_next.bank_off + OFF_W'(bank_bits_reg);
                layout_next.end_off  = layout_next.row_off + OFF_W'(row_bits_reg);
            end
            SCHEME_OPEN_PAGE:
            begin
                layout_next.mode     = MODE_PEEL;
                layout_next.cola_w   = 5'(lo_w);
                layout_next.chan_w   = chan_bits_reg;
                layout_next.colb_w   = hi_w;
                layout_next.bank_w   = bank_bits_reg;
                layout_next.rank_w   = rank_bits_reg;
                layout_next.row_w    = row_bits_reg;
                layout_next.cola_off = OFF_W'(col_size_bits_reg);
                layout_next.chan_off = layout_next.cola_off + OFF_W'(lo_w);
                layout_next.colb_off = layout_next.chan_off + OFF_W'(chan_bits_reg);
                layout_next.bank_off = layout_next.colb_off + OFF_W'(hi_w);
                layout_next.rank_off = layout_next.bank_off + OFF_W'(bank_bits_reg);
                layout_next.row_off  = layout_next.rank_off + OFF_W'(rank_bits_reg);
                layout_next.end_off  = layout_next.row_off + OFF_W'(row_bits_reg);
            end
            SCHEME_SDRAM:
            begin
                layout_next.mode     = MODE_PEEL;
                layout_next.cola_w   = 5'(lo_w);
                layout_next.chan_w   = chan_bits_reg;
                layout_next.colb_w   = hi_w;
                layout_next.bank_w   = bank_bits_reg;
                layout_next.row_w    = row_bits_reg;
                layout_next.rank_w   = rank_bits_reg;
                layout_next.cola_off = OFF_W'(col_size_bits_reg);
                layout_next.chan_off = layout_next.cola_off + OFF_W'(lo_w);
                layout_next.colb_off = layout_next.chan_off + OFF_W'(chan_bits_reg);
                layout_next.bank_off = layout_next.colb_off + OFF_W'(hi_w);
                layout_next.row_off  = layout_next.bank_off + OFF_W'(bank_bits_reg);
                layout_next.rank_off = layout_next.row_off + OFF_W'(row_bits_reg);
                layout_next.end_off  = layout_next.rank_off + OFF_W'(rank_bits_reg);
            end
            SCHEME_FIXED:
            begin
                layout_next.mode = MODE_FIXED;
            end
            SCHEME_CLOSE_PAGE:
            begin
                layout_next.mode     = MODE_PEEL;
                layout_next.cola_w   = 5'(lo_w);
                layout_next.chan_w   = chan_bits_reg;
                layout_next.bank_w   = bank_bits_reg;
                layout_next.rank_w   = rank_bits_reg;
                layout_next.colb_w   = hi_w;
                layout_next.row_w    = row_bits_reg;
                layout_next.cola_off = OFF_W'(col_size_bits_reg);
                layout_next.chan_off = layout_next.cola_off + OFF_W'(lo_w);
                layout_next.bank_off = layout_next.chan_off + OFF_W'(chan_bits_reg);
                layout_next.rank_off = layout_next.bank_off + OFF_W'(bank_bits_reg);
                layout_next.colb_off = layout_next.rank_off + OFF_W'(rank_bits_reg);
                layout_next.row_off  = layout_next.colb_off + OFF_W'(hi_w);
                layout_next.end_off  = layout_next.row_off + OFF_W'(row_bits_reg);
            end
            default:
            begin
                layout_next.mode = MODE_BAD;
            end
        endcase
    end

    // layout register, reloaded every cycle from the config registers
    always_ff @(posedge clk)
    begin
        layout_reg <= layout_next;
    end

    assign layout = layout_reg;

endmodule

[rtl/core/dam_decode.sv]
// dram address mapper decode stage: field extraction from the registered
// request address under the registered layout, into the result register
// depends on dam_pkg
module dam_decode (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_vld,
    input  logic [dam_pkg::PHYS_ADDR_W-1:0]     addr,
    input  dam_pkg::layout_t                    layout,
    output logic                                done,
    output logic [dam_pkg::CHAN_ID_W-1:0]       chan_id,
    output logic [dam_pkg::RANK_ID_W-1:0]       rank_id,
    output logic [dam_pkg::BANK_ID_W-1:0]       bank_id,
    output logic [dam_pkg::ROW_ID_W-1:0]        row_id,
    output logic [dam_pkg::COL_ID_W-1:0]        col_id,
    output logic                                out_of_range,
    output logic                                bad_scheme
);
    import dam_pkg::*;

    logic [PHYS_ADDR_W-1:0] chan_v;
    logic [PHYS_ADDR_W-1:0] rank_v;
    logic [PHYS_ADDR_W-1:0] bank_v;
    logic [PHYS_ADDR_W-1:0] row_v;
    logic [PHYS_ADDR_W-1:0] cola_v;
    logic [PHYS_ADDR_W-1:0] colb_v;

    logic                 done_reg;
    logic [CHAN_ID_W-1:0] chan_next, chan_reg;
    logic [RANK_ID_W-1:0] rank_next, rank_reg;
    logic [BANK_ID_W-1:0] bank_next, bank_reg;
    logic [ROW_ID_W-1:0]  row_next, row_reg;
    logic [COL_ID_W-1:0]  col_next, col_reg;
    logic                 oor_next, oor_reg;
    logic                 bad_next, bad_reg;

    // peeled fields, each one shifter and mask
    always_comb
    begin
        chan_v = field_extract(addr, layout.chan_off, 5'(layout.chan_w));
        rank_v = field_extract(addr, layout.rank_off, 5'(layout.rank_w));
        bank_v = field_extract(addr, layout.bank_off, 5'(layout.bank_w));
        row_v  = field_extract(addr, layout.row_off, layout.row_w);
        cola_v = field_extract(addr, layout.cola_off, layout.cola_w);
        colb_v = field_extract(addr, layout.colb_off, layout.colb_w);
    end

    // result select by decode mode
    always_comb
    begin
        chan_next = '0;
        rank_next = '0;
        bank_next = '0;
        row_next  = '0;
        col_next  = '0;
        oor_next  = 1'b0;
        bad_next  = 1'b0;
        unique case (layout.mode)
            MODE_PEEL:
            begin
                chan_next = chan_v[CHAN_ID_W-1:0];
                rank_next = rank_v[RANK_ID_W-1:0];
                bank_next = bank_v[BANK_ID_W-1:0];
                row_next  = row_v[ROW_ID_W-1:0];
                col_next  = cola_v[COL_ID_W-1:0]
                          | (colb_v[COL_ID_W-1:0] << layout.cola_w);
                oor_next  = bits_above(addr, layout.end_off);
            end
            MODE_FIXED:
            begin
                col_next  = COL_ID_W'(addr[FIX_COL_LSB +: FIX_COL_BITS]);
                bank_next = BANK_ID_W'(addr[FIX_BANK_LSB +: 2]);
                // row bit 11 stays zero between the middle bits and bit 15
                row_next  = (ROW_ID_W'(addr[FIX_BIT27]) << FIX_ROW_TOP_POS)
                          | (ROW_ID_W'(addr[FIX_BIT15]) << FIX_ROW_B15_POS)
                          | ROW_ID_W'(addr[FIX_MID_LSB +: FIX_MID_BITS]);
                rank_next = RANK_ID_W'(addr[FIX_RANK_LSB +: 2]);
                oor_next  = |addr[PHYS_ADDR_W-1:FIX_TOP_LSB];
            end
            MODE_BAD:
            begin
                bad_next = 1'b1;
            end
            default:
            begin
                bad_next = 1'b1;
            end
        endcase
    end

    // result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= in_vld;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (in_vld)
        begin
            chan_reg <= chan_next;
            rank_reg <= rank_next;
            bank_reg <= bank_next;
            row_reg  <= row_next;
            col_reg  <= col_next;
            oor_reg  <= oor_next;
            bad_reg  <= bad_next;
        end
    end

    assign done         = done_reg;
    assign chan_id      = chan_reg;
    assign rank_id      = rank_reg;
    assign bank_id      = bank_reg;
    assign row_id       = row_reg;
    assign col_id       = col_reg;
    assign out_of_range = oor_reg;
    assign bad_scheme   = bad_reg;

endmodule

[rtl/core/dram_address_mapper_unit.sv]
// dram address mapper top level: request register, configuration block
// and decode stage
// depends on dam_pkg, dam_cfg, dam_decode
// a taken request is registered, then decoded into the result register as done rises
// throughput: one request per cycle, set by the single register stage before decode
// busy is never raised and the receiver cannot stall; done is high for one cycle per result
// reset: registers return to scheme open page and default depths, strobes clear
module dram_address_mapper_unit #(
    parameter int ADDR_WIDTH = dam_pkg::ADDR_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [dam_pkg::PHYS_ADDR_W-1:0]     mem_addr,
    output logic                                done,
    output logic [dam_pkg::CHAN_ID_W-1:0]       chan_id,
    output logic [dam_pkg::RANK_ID_W-1:0]       rank_id,
    output logic [dam_pkg::BANK_ID_W-1:0]       bank_id,
    output logic [dam_pkg::ROW_ID_W-1:0]        row_id,
    output logic [dam_pkg::COL_ID_W-1:0]        col_id,
    output logic                                out_of_range,
    output logic                                bad_scheme,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [dam_pkg::CFG_ADDR_W-1:0]      paddr,
    input  logic [dam_pkg::CFG_DATA_W-1:0]      pwdata,
    output logic [dam_pkg::CFG_DATA_W-1:0]      prdata,
    output logic                                pready
);
    import dam_pkg::*;

    // address bits above ADDR_WIDTH are ignored
    localparam logic [63:0] FullMask = {64{1'b1}} >> (64 - ADDR_WIDTH);
    localparam logic [PHYS_ADDR_W-1:0] AddrMask = FullMask[PHYS_ADDR_W-1:0];

    logic                   req_vld_reg;
    logic [PHYS_ADDR_W-1:0] req_addr_reg;
    logic                   req_take;
    layout_t                layout;

    assign busy     = 1'b0;
    assign req_take = start && !busy;

    // request valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_vld_reg <= 1'b0;
        end
        else
        begin
            req_vld_reg <= req_take;
        end
    end

    // request address, masked to the used width
    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            req_addr_reg <= mem_addr & AddrMask;
        end
    end

    // configuration registers and layout
    dam_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .layout  (layout)
    );

    // field decode and result register
    dam_decode u_decode (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_vld       (req_vld_reg),
        .addr         (req_addr_reg),
        .layout       (layout),
        .done         (done),
        .chan_id      (chan_id),
        .rank_id      (rank_id),
        .bank_id      (bank_id),
        .row_id       (row_id),
        .col_id       (col_id),
        .out_of_range (out_of_range),
        .bad_scheme   (bad_scheme)
    );

endmodule

[test/testbench.sv]
// testbench for the dram address mapper: directed and random address requests,
// checked against an in-bench model of the field split, under many register settings
// depends on dam_pkg and dram_address_mapper_unit
`timescale 1ns / 1ps

module testbench;

    import dam_pkg::*;

    // scheme codes the block does not know
    localparam logic [2:0] SCHEME_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] SCHEME_UNUSED_LAST  = 3'd7;

    // largest legal depths and largest values the register fields hold
    localparam int SMALL_DEPTH_MAX = 4;
    localparam int SMALL_DEPTH_REG = 7;
    localparam int ROW_DEPTH_MAX   = 20;
    localparam int COL_DEPTH_MAX   = 16;
    localparam int WIDE_DEPTH_REG  = 31;
    localparam int CSZ_DEPTH_MAX   = 6;
    localparam int LINE_DEPTH_MAX  = 10;
    localparam int LINE_DEPTH_REG  = 15;

    localparam int RAND_PHASES     = 35;
    localparam int PHASE_REQUESTS  = 20;
    localparam int WATCHDOG_LIMIT  = 1000;
    localparam int TAIL_CYCLES     = 10;
    localparam int SHOWN_MISMATCHES = 10;

    // one decoded address
    typedef struct packed {
        logic [CHAN_ID_W-1:0] chan;
        logic [RANK_ID_W-1:0] rank;
        logic [BANK_ID_W-1:0] bank;
        logic [ROW_ID_W-1:0]  row;
        logic [COL_ID_W-1:0]  col;
        logic                 oor;
        logic                 bad;
    } dram_coord_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    start = 1'b0;
    logic                    busy;
    logic [PHYS_ADDR_W-1:0]  mem_addr = '0;
    logic                    done;
    logic [CHAN_ID_W-1:0]    chan_id;
    logic [RANK_ID_W-1:0]    rank_id;
    logic [BANK_ID_W-1:0]    bank_id;
    logic [ROW_ID_W-1:0]     row_id;
    logic [COL_ID_W-1:0]     col_id;
    logic                    out_of_range;
    logic                    bad_scheme;
    logic                    psel = 1'b0;
    logic                    penable = 1'b0;
    logic                    pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0]   paddr = '0;
    logic [CFG_DATA_W-1:0]   pwdata = '0;
    logic [CFG_DATA_W-1:0]   prdata;
    logic                    pready;

    // register copy used for prediction
    logic [2:0] cur_scheme = RST_MAP_SCHEME;
    int         cur_chan_w = RST_CHAN_BITS;
    int         cur_rank_w = RST_RANK_BITS;
    int         cur_bank_w = RST_BANK_BITS;
    int         cur_row_w  = RST_ROW_BITS;
    int         cur_col_w  = RST_COL_BITS;
    int         cur_csz_w  = RST_COL_SIZE_BITS;
    int         cur_line_w = RST_LINE_BITS;

    logic [PHYS_ADDR_W-1:0] addr_queue[$];
    dram_coord_t            expected_coords[$];
    logic                   req_taken = 1'b0;
    int                     sender_idle_pct = 11;
    int                     mismatch_count = 0;
    int                     stall_cycles = 0;

    dram_address_mapper_unit DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .mem_addr     (mem_addr),
        .done         (done),
        .chan_id      (chan_id),
        .rank_id      (rank_id),
        .bank_id      (bank_id),
        .row_id       (row_id),
        .col_id       (col_id),
        .out_of_range (out_of_range),
        .bad_scheme   (bad_scheme),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #5 clk = ~clk;

    // remove the low n bits of rest and return them
    function automatic logic [63:0] take_bits(inout logic [63:0] rest, input int n);
        logic [63:0] v;
        begin
            v    = rest & ((64'd1 << n) - 64'd1);
            rest = rest >> n;
            return v;
        end
    endfunction

    // split an address under the current register copy
    function automatic dram_coord_t map_address(input logic [PHYS_ADDR_W-1:0] addr);
        logic [63:0] rest;
        logic [63:0] chan, rank, bank, row, col, lo, hi;
        logic        oor, bad;
        int          lo_w, hi_w;
        dram_coord_t r;
        begin
            rest = {32'd0, addr} >> cur_csz_w;
            lo_w = (cur_line_w > cur_csz_w) ? cur_line_w - cur_csz_w : 0;
            hi_w = (cur_col_w > lo_w) ? cur_col_w - lo_w : 0;
            chan = 0; rank = 0; bank = 0; row = 0; col = 0; lo = 0; hi = 0;
            oor  = 1'b0;
            bad  = 1'b0;
            case (cur_scheme)
                SCHEME_BURGER: begin
                    chan = take_bits(rest, cur_chan_w);
                    col  = take_bits(rest, cur_col_w);
                    rank = take_bits(rest, cur_rank_w);
                    bank = take_bits(rest, cur_bank_w);
                    row  = take_bits(rest, cur_row_w);
                    oor  = rest != 0;
                end
                SCHEME_OPEN_PAGE: begin
                    lo   = take_bits(rest, lo_w);
                    chan = take_bits(rest, cur_chan_w);
                    hi   = take_bits(rest, hi_w);
                    bank = take_bits(rest, cur_bank_w);
                    rank = take_bits(rest, cur_rank_w);
                    row  = take_bits(rest, cur_row_w);
                    oor  = rest != 0;
                end
                SCHEME_SDRAM: begin
                    lo   = take_bits(rest, lo_w);
                    chan = take_bits(rest, cur_chan_w);
                    hi   = take_bits(rest, hi_w);
                    bank = take_bits(rest, cur_bank_w);
                    row  = take_bits(rest, cur_row_w);
                    rank = take_bits(rest, cur_rank_w);
                    oor  = rest != 0;
                end
                SCHEME_FIXED: begin
                    col  = 64'((addr >> FIX_COL_LSB) & ((32'd1 << FIX_COL_BITS) - 32'd1));
                    bank = 64'((addr >> FIX_BANK_LSB) & 32'd3);
                    row  = (64'(addr[FIX_BIT27]) << 13) | (64'(addr[FIX_BIT15]) << 12)
                         | 64'((addr >> FIX_MID_LSB) & ((32'd1 << FIX_MID_BITS) - 32'd1));
                    rank = 64'((addr >> FIX_RANK_LSB) & 32'd3);
                    oor  = (addr >> FIX_TOP_LSB) != 0;
                end
                SCHEME_CLOSE_PAGE: begin
                    lo   = take_bits(rest, lo_w);
                    chan = take_bits(rest, cur_chan_w);
                    bank = take_bits(rest, cur_bank_w);
                    rank = take_bits(rest, cur_rank_w);
                    hi   = take_bits(rest, hi_w);
                    row  = take_bits(rest, cur_row_w);
                    oor  = rest != 0;
                end
                default: bad = 1'b1;
            endcase
            // split column schemes rebuild the column from both parts
            if (cur_scheme == SCHEME_OPEN_PAGE || cur_scheme == SCHEME_SDRAM
                || cur_scheme == SCHEME_CLOSE_PAGE)
                col = (hi << lo_w) | lo;
            r.chan = chan[CHAN_ID_W-1:0];
            r.rank = rank[RANK_ID_W-1:0];
            r.bank = bank[BANK_ID_W-1:0];
            r.row  = row[ROW_ID_W-1:0];
            r.col  = col[COL_ID_W-1:0];
            r.oor  = oor;
            r.bad  = bad;
            return r;
        end
    endfunction

    // request driver: holds start until taken, idles at random
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!start || req_taken)
            begin
                if (addr_queue.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct)
                begin
                    start    <= 1'b1;
                    mem_addr <= addr_queue.pop_front();
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // monitor: check results, predict taken requests, watchdog
    always @(posedge clk)
    begin
        dram_coord_t got;
        dram_coord_t want;
        logic        moved;
        if (rst_n)
        begin
            moved = 1'b0;
            if (done)
            begin
                moved = 1'b1;
                got = '{chan_id, rank_id, bank_id, row_id, col_id, out_of_range, bad_scheme};
                if (expected_coords.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= SHOWN_MISMATCHES)
                        $display("unexpected result: chan %0h rank %0h bank %0h",
                                 got.chan, got.rank, got.bank,
                                 " row %0h col %0h oor %0b bad %0b",
                                 got.row, got.col, got.oor, got.bad);
                end
                else
                begin
                    want = expected_coords.pop_front();
                    if (got != want)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= SHOWN_MISMATCHES)
                            $display("mismatch: exp chan %0h rank %0h bank %0h",
                                     want.chan, want.rank, want.bank,
                                     " row %0h col %0h oor %0b bad %0b,",
                                     want.row, want.col, want.oor, want.bad,
                                     " got chan %0h rank %0h bank %0h",
                                     got.chan, got.rank, got.bank,
                                     " row %0h col %0h oor %0b bad %0b",
                                     got.row, got.col, got.oor, got.bad);
                    end
                end
            end
            req_taken = start && !busy;
            if (req_taken)
            begin
                moved = 1'b1;
                expected_coords.push_back(map_address(mem_addr));
            end
            stall_cycles = moved ? 0 : stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // one register write: setup phase then access phase
    task automatic apb_write(input logic [2:0] idx, input int value);
        begin
            @(negedge clk);
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= CFG_ADDR_W'({idx, 2'b00});
            pwdata  <= CFG_DATA_W'(value);
            @(negedge clk);
            penable <= 1'b1;
            @(posedge clk);
            while (!pready)
                @(posedge clk);
            @(negedge clk);
            psel    <= 1'b0;
            penable <= 1'b0;
            pwrite  <= 1'b0;
        end
    endtask

    // wait until no request is pending, in flight or awaiting its result
    task automatic wait_for_drain();
        begin
            @(negedge clk);
            #1;
            while (addr_queue.size() != 0 || expected_coords.size() != 0 || start)
            begin
                @(negedge clk);
                #1;
            end
        end
    endtask

    // program every register once the block is idle
    task automatic program_mapping(input int scheme, input int chan_w, input int rank_w,
                                   input int bank_w, input int row_w, input int col_w,
                                   input int csz_w, input int line_w);
        begin
            wait_for_drain();
            apb_write(REG_MAP_SCHEME, scheme);
            cur_scheme = 3'(scheme);
            apb_write(REG_CHAN_BITS, chan_w);
            cur_chan_w = chan_w;
            apb_write(REG_RANK_BITS, rank_w);
            cur_rank_w = rank_w;
            apb_write(REG_BANK_BITS, bank_w);
            cur_bank_w = bank_w;
            apb_write(REG_ROW_BITS, row_w);
            cur_row_w = row_w;
            apb_write(REG_COL_BITS, col_w);
            cur_col_w = col_w;
            apb_write(REG_COL_SIZE_BITS, csz_w);
            cur_csz_w = csz_w;
            apb_write(REG_LINE_BITS, line_w);
            cur_line_w = line_w;
        end
    endtask

    // depth with extra weight on the ends, sometimes past the legal top
    function automatic int pick_depth(input int legal_max, input int reg_max);
        int r;
        begin
            r = $urandom_range(0, 99);
            if (r < 15)
                return 0;
            else if (r < 30)
                return legal_max;
            else if (r < 38)
                return $urandom_range(legal_max, reg_max);
            else
                return $urandom_range(0, legal_max);
        end
    endfunction

    // stimulus
    initial
    begin
        int scheme;
        int k;
        logic [PHYS_ADDR_W-1:0] a;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        // reset settings
        addr_queue.push_back(32'h0000_0000);
        addr_queue.push_back(32'hFFFF_FFFF);
        addr_queue.push_back(32'h1234_5678);

        program_mapping(SCHEME_BURGER, 1, 2, 2, 13, 10, 3, 6);
        addr_queue.push_back(32'hA5A5_A5A5);
        addr_queue.push_back(32'h00FF_FFFF);

        program_mapping(SCHEME_SDRAM, 2, 1, 3, 14, 11, 2, 7);
        addr_queue.push_back(32'h5A5A_5A5A);
        addr_queue.push_back(32'h0000_FFFF);

        // fixed layout: top of range, first bit above, the two odd row bits
        program_mapping(SCHEME_FIXED, 0, 2, 2, 13, 10, 3, 6);
        addr_queue.push_back(32'h3FFF_FFFF);
        addr_queue.push_back(32'h4000_0000);
        addr_queue.push_back(32'h0800_8000);
        addr_queue.push_back(32'hFFFF_FFFF);

        // line smaller than column size: no low column part
        program_mapping(SCHEME_CLOSE_PAGE, SMALL_DEPTH_MAX, SMALL_DEPTH_MAX, SMALL_DEPTH_MAX,
                        ROW_DEPTH_MAX, COL_DEPTH_MAX, CSZ_DEPTH_MAX, 0);
        addr_queue.push_back(32'hFFFF_FFFF);
        addr_queue.push_back(32'h8765_4321);

        // column narrower than the low part: no high column part
        program_mapping(SCHEME_OPEN_PAGE, 3, 1, 2, 8, 0, 0, LINE_DEPTH_MAX);
        addr_queue.push_back(32'hC3C3_C3C3);
        addr_queue.push_back(32'h0000_0400);

        // unknown schemes
        program_mapping(SCHEME_UNUSED_FIRST, 1, 2, 2, 13, 10, 3, 6);
        addr_queue.push_back(32'hDEAD_BEEF);
        program_mapping(SCHEME_UNUSED_FIRST + 3'd1, 1, 2, 2, 13, 10, 3, 6);
        addr_queue.push_back(32'hFFFF_FFFF);
        program_mapping(SCHEME_UNUSED_LAST, 1, 2, 2, 13, 10, 3, 6);
        addr_queue.push_back(32'h0000_0001);

        // fields wider than their outputs, depth sum past the address
        program_mapping(SCHEME_BURGER, SMALL_DEPTH_REG, SMALL_DEPTH_REG, SMALL_DEPTH_REG,
                        WIDE_DEPTH_REG, WIDE_DEPTH_REG, 0, LINE_DEPTH_REG);
        addr_queue.push_back(32'hFFFF_FFFF);
        addr_queue.push_back(32'h1357_9BDF);

        // all depths zero: every address bit is left over
        program_mapping(SCHEME_OPEN_PAGE, 0, 0, 0, 0, 0, 0, 0);
        addr_queue.push_back(32'h0000_0001);
        addr_queue.push_back(32'h0000_0000);

        // random settings, each with a batch of random addresses
        for (int p = 0; p < RAND_PHASES; p++)
        begin
            if ($urandom_range(0, 9) == 0)
                scheme = $urandom_range(SCHEME_UNUSED_FIRST, SCHEME_UNUSED_LAST);
            else
                scheme = $urandom_range(SCHEME_BURGER, SCHEME_CLOSE_PAGE);
            program_mapping(scheme,
                            pick_depth(SMALL_DEPTH_MAX, SMALL_DEPTH_REG),
                            pick_depth(SMALL_DEPTH_MAX, SMALL_DEPTH_REG),
                            pick_depth(SMALL_DEPTH_MAX, SMALL_DEPTH_REG),
                            pick_depth(ROW_DEPTH_MAX, WIDE_DEPTH_REG),
                            pick_depth(COL_DEPTH_MAX, WIDE_DEPTH_REG),
                            pick_depth(CSZ_DEPTH_MAX, SMALL_DEPTH_REG),
                            pick_depth(LINE_DEPTH_MAX, LINE_DEPTH_REG));
            if (p < RAND_PHASES / 3)
                sender_idle_pct = 11;
            else if (p < 2 * RAND_PHASES / 3)
                sender_idle_pct = 87;
            else
                sender_idle_pct = 0;
            for (int i = 0; i < PHASE_REQUESTS; i++)
            begin
                k = $urandom_range(0, 31);
                case ($urandom_range(0, 5))
                    0, 1: a = $urandom;
                    // short addresses so the left over bits come and go
                    2: a = $urandom & ~(32'hFFFF_FFFF << k);
                    3: a = 32'd1 << k;
                    4: a = ~(32'd1 << k);
                    default: a = $urandom >> k;
                endcase
                addr_queue.push_back(a);
            end
        end

        // drain and let any stray result show up
        wait_for_drain();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (mismatch_count == 0 && expected_coords.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

[files.f]
rtl/core/dam_pkg.sv
rtl/core/dam_cfg.sv
rtl/core/dam_decode.sv
rtl/core/dram_address_mapper_unit.sv
test/testbench.sv
